[hw/rtl/pfb_pkg.sv]
// ----------------------------------------------------------------------------
// Packed frame buffer package
// Operation codes, status codes, fill values and the request and response
// structures of the packed 1 bit per pixel frame buffer draw engine.
// ----------------------------------------------------------------------------
package pfb_pkg;

  typedef enum logic [2:0] {
    OP_SET_PIXEL = 3'd0,
    OP_RECT      = 3'd1,
    OP_CLEAR     = 3'd2,
    OP_FILL      = 3'd3,
    OP_READ      = 3'd4
  } op_e;

  localparam logic STATUS_OK      = 1'b0;
  localparam logic STATUS_INVALID = 1'b1;

  localparam logic [7:0] BYTE_CLEAR = 8'hFF;
  localparam logic [7:0] BYTE_FILL  = 8'h00;

  typedef struct packed {
    logic [2:0]         opcode;
    logic signed [11:0] x_first;
    logic signed [11:0] y_first;
    logic signed [11:0] x_second;
    logic signed [11:0] y_second;
    logic               color;
    logic [13:0]        byte_index;
  } req_t;

  typedef struct packed {
    logic       status;
    logic [7:0] read_data;
  } rsp_t;

endpackage

[hw/rtl/pfb_store.sv]
// ----------------------------------------------------------------------------
// Frame store
// Byte memory with one write port and one registered read port; read data
// appears in the cycle after the read enable.
// ----------------------------------------------------------------------------
module pfb_store #(
  parameter int unsigned Depth = 15000,
  localparam int unsigned AddrW = $clog2(Depth)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [7:0]       wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [7:0]       rdata_o
);

  logic [7:0] mem_q [Depth];
  logic [7:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[hw/rtl/packed_framebuffer_draw_engine_unit.sv]
// ----------------------------------------------------------------------------
// Packed frame buffer draw engine
// Draws into a 1 bit per pixel frame store in which each byte covers two
// columns by four rows, with rows counted from the bottom of the panel.
//
// A request is transferred when start is high and busy is low. Every request
// produces exactly one response, shown on rsp_o for one cycle with done_o
// high; the receiver cannot stall it and must take it in that cycle.
// Rejected pixels, bad read indices, unknown opcodes and empty rectangles are
// answered straight from idle. A read passes through the fetch and read data
// states; a set pixel or a rectangle makes one read-modify-write per pixel;
// clear all and fill all sweep every byte of the store.
// Each pixel is a read-modify-write of the store through its single
// registered read port: address, read, write back. Clear and fill write one
// byte per cycle. busy drops in the cycle that done_o rises, so a new
// request may be transferred while the response is shown.
// After reset the engine sweeps the store to 0xFF, one byte per cycle, with
// busy high; this sweep gives no response.
// ----------------------------------------------------------------------------
module packed_framebuffer_draw_engine_unit #(
  parameter int unsigned PANEL_WIDTH  = 400,
  parameter int unsigned PANEL_HEIGHT = 300,
  parameter int unsigned FRAME_BYTES  = 15000
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start,
  output logic          busy,
  input  pfb_pkg::req_t req_i,
  output logic          done_o,
  output pfb_pkg::rsp_t rsp_o
);

  localparam int unsigned AddrW = $clog2(FRAME_BYTES);
  localparam logic signed [11:0] XMax = 12'(PANEL_WIDTH - 1);
  localparam logic signed [11:0] YMax = 12'(PANEL_HEIGHT - 1);
  localparam logic [10:0] YTop = 11'(PANEL_HEIGHT - 1);
  localparam logic [9:0] RowBytes = 10'(PANEL_HEIGHT / 4);
  localparam logic [AddrW-1:0] LastAddr = AddrW'(FRAME_BYTES - 1);

  typedef enum logic [6:0] {
    ST_IDLE  = 7'b0000001,
    ST_SWEEP = 7'b0000010,
    ST_ADDR  = 7'b0000100,
    ST_READ  = 7'b0001000,
    ST_WRITE = 7'b0010000,
    ST_FETCH = 7'b0100000,
    ST_RDATA = 7'b1000000
  } state_e;

  state_e state_q, state_d;
  logic [10:0] cur_x_q, cur_x_d, cur_y_q, cur_y_d;
  logic [10:0] x_lo_q, x_lo_d, x_hi_q, x_hi_d, y_hi_q, y_hi_d;
  logic color_q, color_d;
  logic [AddrW-1:0] addr_q, addr_d, cnt_q, cnt_d;
  logic [7:0] mask_q, mask_d, fill_q, fill_d;
  logic wr_ok_q, wr_ok_d;
  logic sweep_rsp_q, sweep_rsp_d;
  logic done_q, done_d;
  pfb_pkg::rsp_t rsp_q, rsp_d;

  logic signed [11:0] xa, xb, ya, yb, xs, xe, ys, ye;
  logic rect_empty, pix_off, read_bad;
  logic [10:0] fy;
  logic [19:0] prod;
  logic [20:0] idx;

  logic mem_we, mem_re;
  logic [AddrW-1:0] mem_waddr;
  logic [7:0] mem_wdata, mem_rdata;

  // Rectangle corners are ordered, then clipped to the panel.
  always_comb begin
    xa = (req_i.x_first < req_i.x_second) ? req_i.x_first : req_i.x_second;
    xb = (req_i.x_first < req_i.x_second) ? req_i.x_second : req_i.x_first;
    ya = (req_i.y_first < req_i.y_second) ? req_i.y_first : req_i.y_second;
    yb = (req_i.y_first < req_i.y_second) ? req_i.y_second : req_i.y_first;
    xs = (xa < 12'sd0) ? 12'sd0 : xa;
    ys = (ya < 12'sd0) ? 12'sd0 : ya;
    xe = (xb > XMax) ? XMax : xb;
    ye = (yb > YMax) ? YMax : yb;
    rect_empty = (xs > xe) || (ys > ye);
    pix_off = (req_i.x_first < 12'sd0) || (req_i.y_first < 12'sd0) ||
              (req_i.x_first > XMax) || (req_i.y_first > YMax);
    read_bad = {1'b0, req_i.byte_index} >= 15'(FRAME_BYTES);
  end

  // Byte address of the current pixel; rows are flipped so row 0 is at the
  // bottom of each column pair.
  always_comb begin
    fy   = YTop - cur_y_q;
    prod = 20'(cur_x_q[10:1]) * 20'(RowBytes);
    idx  = 21'(prod) + 21'(fy[10:2]);
  end

  always_comb begin
    state_d     = state_q;
    cur_x_d     = cur_x_q;
    cur_y_d     = cur_y_q;
    x_lo_d      = x_lo_q;
    x_hi_d      = x_hi_q;
    y_hi_d      = y_hi_q;
    color_d     = color_q;
    addr_d      = addr_q;
    cnt_d       = cnt_q;
    mask_d      = mask_q;
    fill_d      = fill_q;
    wr_ok_d     = wr_ok_q;
    sweep_rsp_d = sweep_rsp_q;
    done_d      = 1'b0;
    rsp_d       = rsp_q;
    mem_we      = 1'b0;
    mem_re      = 1'b0;
    mem_waddr   = addr_q;
    mem_wdata   = color_q ? (mem_rdata | mask_q) : (mem_rdata & ~mask_q);

    case (state_q)
      ST_IDLE: begin
        if (start) begin
          case (req_i.opcode)
            pfb_pkg::OP_SET_PIXEL: begin
              if (pix_off) begin
                done_d = 1'b1;
                rsp_d  = '{status: pfb_pkg::STATUS_INVALID, read_data: 8'h00};
              end else begin
                cur_x_d = req_i.x_first[10:0];
                x_lo_d  = req_i.x_first[10:0];
                x_hi_d  = req_i.x_first[10:0];
                cur_y_d = req_i.y_first[10:0];
                y_hi_d  = req_i.y_first[10:0];
                color_d = req_i.color;
                state_d = ST_ADDR;
              end
            end
            pfb_pkg::OP_RECT: begin
              if (rect_empty) begin
                done_d = 1'b1;
                rsp_d  = '{status: pfb_pkg::STATUS_OK, read_data: 8'h00};
              end else begin
                cur_x_d = xs[10:0];
                x_lo_d  = xs[10:0];
                x_hi_d  = xe[10:0];
                cur_y_d = ys[10:0];
                y_hi_d  = ye[10:0];
                color_d = req_i.color;
                state_d = ST_ADDR;
              end
            end
            pfb_pkg::OP_CLEAR: begin
              fill_d      = pfb_pkg::BYTE_CLEAR;
              cnt_d       = '0;
              sweep_rsp_d = 1'b1;
              state_d     = ST_SWEEP;
            end
            pfb_pkg::OP_FILL: begin
              fill_d      = pfb_pkg::BYTE_FILL;
              cnt_d       = '0;
              sweep_rsp_d = 1'b1;
              state_d     = ST_SWEEP;
            end
            pfb_pkg::OP_READ: begin
              if (read_bad) begin
                done_d = 1'b1;
                rsp_d  = '{status: pfb_pkg::STATUS_INVALID, read_data: 8'h00};
              end else begin
                addr_d  = req_i.byte_index[AddrW-1:0];
                state_d = ST_FETCH;
              end
            end
            default: begin
              done_d = 1'b1;
              rsp_d  = '{status: pfb_pkg::STATUS_INVALID, read_data: 8'h00};
            end
          endcase
        end
      end
      ST_SWEEP: begin
        mem_we    = 1'b1;
        mem_waddr = cnt_q;
        mem_wdata = fill_q;
        if (cnt_q == LastAddr) begin
          state_d = ST_IDLE;
          done_d  = sweep_rsp_q;
          rsp_d   = '{status: pfb_pkg::STATUS_OK, read_data: 8'h00};
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      ST_ADDR: begin
        addr_d  = idx[AddrW-1:0];
        wr_ok_d = idx < 21'(FRAME_BYTES);
        mask_d  = 8'h80 >> {fy[1:0], cur_x_q[0]};
        state_d = ST_READ;
      end
      ST_READ: begin
        mem_re  = 1'b1;
        state_d = ST_WRITE;
      end
      ST_WRITE: begin
        // A pixel whose address falls beyond the store is dropped.
        mem_we  = wr_ok_q;
        state_d = ST_ADDR;
        if (cur_x_q == x_hi_q) begin
          cur_x_d = x_lo_q;
          if (cur_y_q == y_hi_q) begin
            state_d = ST_IDLE;
            done_d  = 1'b1;
            rsp_d   = '{status: pfb_pkg::STATUS_OK, read_data: 8'h00};
          end else begin
            cur_y_d = cur_y_q + 1'b1;
          end
        end else begin
          cur_x_d = cur_x_q + 1'b1;
        end
      end
      ST_FETCH: begin
        mem_re  = 1'b1;
        state_d = ST_RDATA;
      end
      ST_RDATA: begin
        state_d = ST_IDLE;
        done_d  = 1'b1;
        rsp_d   = '{status: pfb_pkg::STATUS_OK, read_data: mem_rdata};
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_SWEEP;
      cnt_q       <= '0;
      fill_q      <= pfb_pkg::BYTE_CLEAR;
      sweep_rsp_q <= 1'b0;
      done_q      <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      fill_q      <= fill_d;
      sweep_rsp_q <= sweep_rsp_d;
      done_q      <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_x_q <= cur_x_d;
    cur_y_q <= cur_y_d;
    x_lo_q  <= x_lo_d;
    x_hi_q  <= x_hi_d;
    y_hi_q  <= y_hi_d;
    color_q <= color_d;
    addr_q  <= addr_d;
    mask_q  <= mask_d;
    wr_ok_q <= wr_ok_d;
    rsp_q   <= rsp_d;
  end

  pfb_store #(
    .Depth(FRAME_BYTES)
  ) u_store (
    .clk_i  (clk_i),
    .we_i   (mem_we),
    .waddr_i(mem_waddr),
    .wdata_i(mem_wdata),
    .re_i   (mem_re),
    .raddr_i(addr_q),
    .rdata_o(mem_rdata)
  );

  assign busy   = (state_q != ST_IDLE);
  assign done_o = done_q;
  assign rsp_o  = rsp_q;

  a_done_when_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy)
    else $error("response shown while a request is still in progress");

  a_no_write_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE) |-> !mem_we)
    else $error("frame store written while idle");

  a_sweep_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SWEEP) |-> (cnt_q <= LastAddr))
    else $error("sweep address beyond the frame store");

  a_read_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && (req_i.opcode == pfb_pkg::OP_READ) && !read_bad)
      |-> ##3 done_o)
    else $error("read response not given three cycles after the transfer");

  a_rmw_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_WRITE) |-> ($past(state_q) == ST_READ))
    else $error("pixel write back without a preceding read");

endmodule
